// ===== hw/rtl/integer_text_parser_with_size_suffix_core_assert.svh =====
// assertion macros for the checker in hw/rtl/itp_checker.sv
`ifndef INTEGER_TEXT_PARSER_WITH_SIZE_SUFFIX_CORE_ASSERT_SVH
`define INTEGER_TEXT_PARSER_WITH_SIZE_SUFFIX_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define ITP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define ITP_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/itp_pkg.sv =====
package itp_pkg;

  // widths
  localparam int OUT_BITS           = 64;
  localparam int DEFAULT_VALUE_BITS = 64;
  localparam int MAX_SUFFIX         = 3;

  // mode register codes
  localparam logic [1:0] MODE_WHOLE  = 2'd0;
  localparam logic [1:0] MODE_PREFIX = 2'd1;
  localparam logic [1:0] MODE_SUFFIX = 2'd2;

  // radix codes
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UK    = 8'h4B;
  localparam logic [7:0] CH_LK    = 8'h6B;
  localparam logic [7:0] CH_UM    = 8'h4D;
  localparam logic [7:0] CH_LM    = 8'h6D;
  localparam logic [7:0] CH_UG    = 8'h47;
  localparam logic [7:0] CH_LG    = 8'h67;
  localparam logic [7:0] CH_UI    = 8'h49;
  localparam logic [7:0] CH_LI    = 8'h69;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LB    = 8'h62;

  // digit code for a character that is no digit in any radix
  localparam logic [5:0] DIGIT_NONE = 6'd63;

  // scan phases
  typedef enum logic [7:0] {
    PH_WS     = 8'b0000_0001,
    PH_SIGN   = 8'b0000_0010,
    PH_ZERO   = 8'b0000_0100,
    PH_PREFIX = 8'b0000_1000,
    PH_DIGITS = 8'b0001_0000,
    PH_TRAIL  = 8'b0010_0000,
    PH_FAIL   = 8'b0100_0000,
    PH_ENDED  = 8'b1000_0000
  } phase_t;

  // end-of-string record leaving the scan stage
  typedef struct packed {
    logic       ok;
    logic       negative;
    logic [1:0] steps;
    logic       bin;
  } fin_t;

  // record through the scale stages
  typedef struct packed {
    logic       ok;
    logic [1:0] steps;
    logic       bin;
  } scl_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if ((c >= CH_0) && (c <= CH_9)) begin
      d = c - CH_0;
    end else if ((c >= CH_LA) && (c <= CH_LZ)) begin
      d = c - CH_LA + 8'd10;
    end else if ((c >= CH_UA) && (c <= CH_UZ)) begin
      d = c - CH_UA + 8'd10;
    end else begin
      d = 8'(DIGIT_NONE);
    end
    return d[5:0];
  endfunction

  function automatic logic [4:0] radix_value(input logic [1:0] sel);
    case (sel)
      RADIX_OCT: return 5'd8;
      RADIX_HEX: return 5'd16;
      default:   return 5'd10;
    endcase
  endfunction

  function automatic logic [1:0] exp_steps(input logic [7:0] c);
    if ((c == CH_LK) || (c == CH_UK)) return 2'd1;
    if ((c == CH_LM) || (c == CH_UM)) return 2'd2;
    if ((c == CH_LG) || (c == CH_UG)) return 2'd3;
    return 2'd0;
  endfunction

  function automatic logic is_unit(input logic [7:0] c);
    return (c == CH_LB) || (c == CH_UB);
  endfunction

  function automatic logic is_bin(input logic [7:0] c);
    return (c == CH_LI) || (c == CH_UI);
  endfunction

endpackage

// ===== hw/rtl/itp_scan.sv =====
module itp_scan #(
  parameter int VALUE_BITS = itp_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            ch,
  input  logic                  last,
  input  logic [1:0]            mode,
  output logic                  fin_valid,
  input  logic                  fin_ready,
  output itp_pkg::fin_t         fin_ctrl,
  output logic [VALUE_BITS-1:0] fin_mag
);
  import itp_pkg::*;

  localparam int PW = VALUE_BITS + 5;
  localparam logic [PW-1:0] VLIMIT = PW'(1) << (VALUE_BITS - 1);

  // input register
  logic       ireg_valid;
  logic [7:0] ireg_ch;
  logic       ireg_last;

  // string state
  phase_t                phase, phase_next;
  logic                  negative, negative_next;
  logic [1:0]            radix_sel, radix_sel_next;
  logic [VALUE_BITS-1:0] magnitude, magnitude_next;
  logic                  range_error, range_error_next;
  logic [2:0]            suffix_count, suffix_count_next;
  logic [7:0]            suffix_chars [MAX_SUFFIX];
  logic [7:0]            suffix_chars_next [MAX_SUFFIX];

  logic       fin_free;
  logic       go;
  logic       detect;
  logic [5:0] dig;
  logic       sign_path;
  logic       acc_do;
  logic [1:0] acc_rsel;
  logic       suf_do;
  logic [PW-1:0] mext;
  logic [PW-1:0] prod;

  logic       sfx_ok;
  logic [1:0] sfx_steps;
  logic       sfx_bin;
  logic       mode_ok;
  logic [1:0] fin_steps;
  logic       fin_bin;
  logic       fin_ok;
  fin_t       fin_rec;

  // handshake: a last item needs room in the end-of-string register
  assign fin_free = !fin_valid || fin_ready;
  assign go       = ireg_valid && (!ireg_last || fin_free);
  assign in_ready = !ireg_valid || go;

  assign detect = (mode != MODE_PREFIX);
  assign dig    = digit_value(ireg_ch);

  // per-character state update
  always_comb begin
    phase_next        = phase;
    negative_next     = negative;
    radix_sel_next    = radix_sel;
    magnitude_next    = magnitude;
    range_error_next  = range_error;
    suffix_count_next = suffix_count;
    suffix_chars_next = suffix_chars;
    sign_path = 1'b0;
    acc_do    = 1'b0;
    acc_rsel  = radix_sel;
    suf_do    = 1'b0;
    mext      = PW'(magnitude);
    prod      = '0;

    if (go && (phase != PH_FAIL) && (phase != PH_ENDED)) begin
      if (ireg_ch == CH_NUL) begin
        if ((phase == PH_WS) || (phase == PH_SIGN) || (phase == PH_PREFIX)) begin
          phase_next = PH_FAIL;
        end else begin
          phase_next = PH_ENDED;
        end
      end else begin
        case (phase)
          PH_WS: begin
            if (is_blank(ireg_ch)) begin
              phase_next = PH_WS;
            end else if ((ireg_ch == CH_PLUS) || (ireg_ch == CH_MINUS)) begin
              negative_next = (ireg_ch == CH_MINUS);
              phase_next    = PH_SIGN;
            end else begin
              sign_path = 1'b1;
            end
          end
          PH_SIGN: begin
            sign_path = 1'b1;
          end
          PH_ZERO: begin
            if (detect && ((ireg_ch == CH_LX) || (ireg_ch == CH_UX))) begin
              phase_next = PH_PREFIX;
            end else if (detect && (dig < 6'd8)) begin
              radix_sel_next = RADIX_OCT;
              phase_next     = PH_DIGITS;
              acc_do         = 1'b1;
              acc_rsel       = RADIX_OCT;
            end else begin
              phase_next = PH_TRAIL;
              suf_do     = 1'b1;
            end
          end
          PH_PREFIX: begin
            if (dig >= 6'd16) begin
              phase_next = PH_FAIL;
            end else begin
              radix_sel_next = RADIX_HEX;
              phase_next     = PH_DIGITS;
              acc_do         = 1'b1;
              acc_rsel       = RADIX_HEX;
            end
          end
          PH_DIGITS: begin
            if (dig < 6'(radix_value(radix_sel))) begin
              acc_do = 1'b1;
            end else begin
              phase_next = PH_TRAIL;
              suf_do     = 1'b1;
            end
          end
          PH_TRAIL: begin
            suf_do = 1'b1;
          end
          default: begin
            phase_next = phase;
          end
        endcase

        // first character after blanks and sign
        if (sign_path) begin
          if (dig > 6'd9) begin
            phase_next = PH_FAIL;
          end else begin
            radix_sel_next = RADIX_DEC;
            acc_rsel       = RADIX_DEC;
            if (detect && (dig == 6'd0)) begin
              phase_next = PH_ZERO;
            end else begin
              phase_next = PH_DIGITS;
              acc_do     = 1'b1;
            end
          end
        end
      end
    end

    // multiply-add with range check: out of range when m*r + d > limit
    case (acc_rsel)
      RADIX_OCT: prod = (mext << 3) + PW'(dig[3:0]);
      RADIX_HEX: prod = (mext << 4) + PW'(dig[3:0]);
      default:   prod = (mext << 3) + (mext << 1) + PW'(dig[3:0]);
    endcase
    if (acc_do && !range_error) begin
      if (prod > VLIMIT) begin
        range_error_next = 1'b1;
      end else begin
        magnitude_next = prod[VALUE_BITS-1:0];
      end
    end

    // suffix capture, count saturates one past the slots
    if (suf_do) begin
      for (int i = 0; i < MAX_SUFFIX; i++) begin
        if (suffix_count == 3'(i)) begin
          suffix_chars_next[i] = ireg_ch;
        end
      end
      if (suffix_count < 3'(MAX_SUFFIX + 1)) begin
        suffix_count_next = suffix_count + 3'd1;
      end
    end
  end

  // suffix decode on the state after this character
  always_comb begin
    sfx_ok    = 1'b0;
    sfx_steps = exp_steps(suffix_chars_next[0]);
    sfx_bin   = 1'b0;
    case (suffix_count_next)
      3'd0: begin
        sfx_ok    = 1'b1;
        sfx_steps = 2'd0;
      end
      3'd1: begin
        sfx_ok = (sfx_steps != 2'd0) || is_unit(suffix_chars_next[0]);
      end
      3'd2: begin
        sfx_ok  = (sfx_steps != 2'd0) &&
                  (is_bin(suffix_chars_next[1]) || is_unit(suffix_chars_next[1]));
        sfx_bin = is_bin(suffix_chars_next[1]);
      end
      3'd3: begin
        sfx_ok  = (sfx_steps != 2'd0) && is_bin(suffix_chars_next[1]) &&
                  is_unit(suffix_chars_next[2]);
        sfx_bin = 1'b1;
      end
      default: begin
        sfx_ok = 1'b0;
      end
    endcase
  end

  // end-of-string checks under the current mode
  always_comb begin
    mode_ok   = 1'b0;
    fin_steps = 2'd0;
    fin_bin   = 1'b0;
    case (mode)
      MODE_PREFIX: begin
        mode_ok = 1'b1;
      end
      MODE_SUFFIX: begin
        mode_ok   = sfx_ok;
        fin_steps = sfx_steps;
        fin_bin   = sfx_bin;
      end
      default: begin
        mode_ok = (suffix_count_next == 3'd0);
      end
    endcase
    fin_ok = mode_ok && !range_error_next &&
             (phase_next != PH_WS) && (phase_next != PH_SIGN) &&
             (phase_next != PH_PREFIX) && (phase_next != PH_FAIL);
    fin_rec.ok       = fin_ok;
    fin_rec.negative = negative_next;
    fin_rec.steps    = fin_ok ? fin_steps : 2'd0;
    fin_rec.bin      = fin_bin;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_ready) begin
      ireg_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      ireg_ch   <= ch;
      ireg_last <= last;
    end
  end

  // string state, cleared after each last item
  always_ff @(posedge clk) begin
    if (rst || (go && ireg_last)) begin
      phase        <= PH_WS;
      negative     <= 1'b0;
      radix_sel    <= RADIX_DEC;
      magnitude    <= '0;
      range_error  <= 1'b0;
      suffix_count <= 3'd0;
      for (int i = 0; i < MAX_SUFFIX; i++) begin
        suffix_chars[i] <= 8'd0;
      end
    end else begin
      phase        <= phase_next;
      negative     <= negative_next;
      radix_sel    <= radix_sel_next;
      magnitude    <= magnitude_next;
      range_error  <= range_error_next;
      suffix_count <= suffix_count_next;
      suffix_chars <= suffix_chars_next;
    end
  end

  // end-of-string register
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_free) begin
      fin_valid <= go && ireg_last;
    end
    if (fin_free && go && ireg_last) begin
      fin_ctrl <= fin_rec;
      fin_mag  <= magnitude_next;
    end
  end

endmodule

// ===== hw/rtl/itp_sign.sv =====
module itp_sign #(
  parameter int VALUE_BITS = itp_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  itp_pkg::fin_t         up_ctrl,
  input  logic [VALUE_BITS-1:0] up_mag,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output itp_pkg::scl_t         dn_ctrl,
  output logic [VALUE_BITS-1:0] dn_value
);
  import itp_pkg::*;

  logic                  load;
  logic                  bad_range;
  logic                  ok;
  logic [VALUE_BITS-1:0] signed_value;
  scl_t                  rec;

  assign load     = !dn_valid || dn_ready;
  assign up_ready = load;

  // positive side stops one below the limit, negative side reaches it
  assign bad_range = up_mag[VALUE_BITS-1] &&
                     (!up_ctrl.negative || (|up_mag[VALUE_BITS-2:0]));
  assign ok = up_ctrl.ok && !bad_range;

  // apply sign, zero on failure
  always_comb begin
    if (!ok) begin
      signed_value = '0;
    end else if (up_ctrl.negative) begin
      signed_value = '0 - up_mag;
    end else begin
      signed_value = up_mag;
    end
    rec.ok    = ok;
    rec.steps = ok ? up_ctrl.steps : 2'd0;
    rec.bin   = up_ctrl.bin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (load) begin
      dn_valid <= up_valid;
    end
    if (load && up_valid) begin
      dn_ctrl  <= rec;
      dn_value <= signed_value;
    end
  end

endmodule

// ===== hw/rtl/itp_scale.sv =====
module itp_scale #(
  parameter int VALUE_BITS = itp_pkg::DEFAULT_VALUE_BITS,
  parameter int STEP       = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  itp_pkg::scl_t         up_ctrl,
  input  logic [VALUE_BITS-1:0] up_value,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output itp_pkg::scl_t         dn_ctrl,
  output logic [VALUE_BITS-1:0] dn_value
);
  import itp_pkg::*;

  logic                  load;
  logic                  apply;
  logic [VALUE_BITS-1:0] times_1024;
  logic [VALUE_BITS-1:0] times_1000;
  logic [VALUE_BITS-1:0] scaled;

  assign load     = !dn_valid || dn_ready;
  assign up_ready = load;

  // one k/m/g step, wrapping at the value width
  assign apply      = (up_ctrl.steps > 2'(STEP));
  assign times_1024 = up_value << 10;
  assign times_1000 = times_1024 - (up_value << 4) - (up_value << 3);

  always_comb begin
    if (!apply) begin
      scaled = up_value;
    end else if (up_ctrl.bin) begin
      scaled = times_1024;
    end else begin
      scaled = times_1000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (load) begin
      dn_valid <= up_valid;
    end
    if (load && up_valid) begin
      dn_ctrl  <= up_ctrl;
      dn_value <= scaled;
    end
  end

endmodule

// ===== hw/rtl/integer_text_parser_with_size_suffix_core.sv =====
// Integer text parser with size suffix.
// Input channel (in_valid / in_stall): one character per item in ch, with
// last set on the final item of a string; ch of zero ends the string early.
// Output channel (out_valid / out_stall): one item per string, ok and a
// 64-bit two's complement value (zero when ok is low).
// Config: cfg_wr_en / cfg_wr_data write the 2-bit mode register, to be
// written between strings only.
// Throughput: one character per cycle, back to back, while in_stall is low;
// the scan stage does the per-character multiply-add and range compare.
// Pipeline: the last character passes the input register, the scan stage's
// end-of-string register, the sign register and three scale stages.
// Reset (rst, synchronous): mode returns to 0, string state is cleared and
// every pipeline stage is emptied.
// Stall: a held result stays on the output; stages behind it keep filling,
// and in_stall rises only once every stage is full and a last character waits.
module integer_text_parser_with_size_suffix_core #(
  parameter int VALUE_BITS = itp_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   ch,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         ok,
  output logic [itp_pkg::OUT_BITS-1:0] value,
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_wr_data
);
  import itp_pkg::*;

  localparam int NSTAGE = 3;

  logic [1:0] mode;

  logic                  in_ready;
  logic                  fin_valid;
  logic                  fin_ready;
  fin_t                  fin_ctrl;
  logic [VALUE_BITS-1:0] fin_mag;

  logic                  stg_valid [NSTAGE+1];
  logic                  stg_ready [NSTAGE+1];
  scl_t                  stg_ctrl  [NSTAGE+1];
  logic [VALUE_BITS-1:0] stg_value [NSTAGE+1];
  logic signed [VALUE_BITS-1:0] result;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_WHOLE;
    end else if (cfg_wr_en) begin
      mode <= cfg_wr_data;
    end
  end

  itp_scan #(.VALUE_BITS(VALUE_BITS)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .last      (last),
    .mode      (mode),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin_ctrl  (fin_ctrl),
    .fin_mag   (fin_mag)
  );

  itp_sign #(.VALUE_BITS(VALUE_BITS)) u_sign (
    .clk      (clk),
    .rst      (rst),
    .up_valid (fin_valid),
    .up_ready (fin_ready),
    .up_ctrl  (fin_ctrl),
    .up_mag   (fin_mag),
    .dn_valid (stg_valid[0]),
    .dn_ready (stg_ready[0]),
    .dn_ctrl  (stg_ctrl[0]),
    .dn_value (stg_value[0])
  );

  // suffix scale chain, one k/m/g step per stage
  for (genvar s = 0; s < NSTAGE; s++) begin : g_scale
    itp_scale #(.VALUE_BITS(VALUE_BITS), .STEP(s)) u_scale (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stg_valid[s]),
      .up_ready (stg_ready[s]),
      .up_ctrl  (stg_ctrl[s]),
      .up_value (stg_value[s]),
      .dn_valid (stg_valid[s+1]),
      .dn_ready (stg_ready[s+1]),
      .dn_ctrl  (stg_ctrl[s+1]),
      .dn_value (stg_value[s+1])
    );
  end

  // output channel from the last scale register
  assign stg_ready[NSTAGE] = !out_stall;
  assign in_stall          = !in_ready;
  assign out_valid         = stg_valid[NSTAGE];
  assign ok                = stg_ctrl[NSTAGE].ok;
  assign result            = stg_value[NSTAGE];
  assign value             = OUT_BITS'(result);

endmodule

// ===== hw/rtl/itp_checker.sv =====
`include "integer_text_parser_with_size_suffix_core_assert.svh"

module itp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         ok,
  input logic [itp_pkg::OUT_BITS-1:0] value
);
  import itp_pkg::*;

  // a held result item keeps its payload
  `ITP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(ok) && $stable(value), "result item changed while stalled")

  // a failed parse carries a zero value
  `ITP_ASSERT_NOW(a_fail_zero, out_valid && !ok, value == {OUT_BITS{1'b0}}, "failed result with nonzero value")

  // reset empties the pipeline
  `ITP_ASSERT_RESET(a_reset_empty, rst, !out_valid, "result item present after reset")

endmodule

bind integer_text_parser_with_size_suffix_core itp_checker u_itp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .ok        (ok),
  .value     (value)
);

// ===== sim/itp_checker.sv =====
`timescale 1ns / 100ps

// watches both channels and the mode port, predicts each parse and compares
module itp_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  ch,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        ok,
  input  logic [63:0] value,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  output int          errors,
  output int          pending
);
  import itp_pkg::*;

  localparam logic [63:0] SIGN_LIMIT = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic        ok;
    logic [63:0] value;
  } parse_result_t;

  parse_result_t parse_q[$];
  parse_result_t head_res;

  // predicted scan state, one string at a time
  logic [1:0]  mode_q;
  phase_t      scan_ph;
  logic        neg_q;
  logic [1:0]  rdx_q;
  logic [63:0] mag_q;
  logic        ovf_q;
  int unsigned sfx_n;
  logic [7:0]  sfx_c [3];
  int          mismatch_n = 0;

  function automatic int unsigned digit_of(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return 32'(c - CH_0);
    if (c >= CH_LA && c <= CH_LZ) return 32'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UZ) return 32'(c - CH_UA) + 10;
    return 99;
  endfunction

  function automatic int unsigned base_of(input logic [1:0] r);
    case (r)
      RADIX_OCT: return 8;
      RADIX_HEX: return 16;
      default:   return 10;
    endcase
  endfunction

  function automatic int unsigned scale_steps(input logic [7:0] c);
    if (c == CH_LK || c == CH_UK) return 1;
    if (c == CH_LM || c == CH_UM) return 2;
    if (c == CH_LG || c == CH_UG) return 3;
    return 0;
  endfunction

  function automatic logic unit_letter(input logic [7:0] c);
    return (c == CH_LB) || (c == CH_UB);
  endfunction

  function automatic logic binary_letter(input logic [7:0] c);
    return (c == CH_LI) || (c == CH_UI);
  endfunction

  task clear_scan();
    scan_ph = PH_WS;
    neg_q = 1'b0;
    rdx_q = RADIX_DEC;
    mag_q = '0;
    ovf_q = 1'b0;
    sfx_n = 0;
    sfx_c[0] = CH_NUL;
    sfx_c[1] = CH_NUL;
    sfx_c[2] = CH_NUL;
  endtask

  task log_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatch_n++;
    $display("%0t mismatch on %s: got %h expected %h", $time, what, got, want);
  endtask

  // multiply-add with sticky range error
  task fold_digit(input int unsigned d);
    logic [63:0] r;
    r = 64'(base_of(rdx_q));
    if (!ovf_q) begin
      if (mag_q > (SIGN_LIMIT - d) / r) ovf_q = 1'b1;
      else mag_q = mag_q * r + d;
    end
  endtask

  task note_suffix(input logic [7:0] c);
    if (sfx_n < 3) sfx_c[sfx_n] = c;
    if (sfx_n < 4) sfx_n++;
  endtask

  // one character through the scan phases
  task scan_char(input logic [7:0] c);
    int unsigned d;
    logic        detect;
    detect = (mode_q != MODE_PREFIX);
    d = digit_of(c);
    if (scan_ph == PH_FAIL || scan_ph == PH_ENDED) return;
    if (c == CH_NUL) begin
      if (scan_ph == PH_WS || scan_ph == PH_SIGN || scan_ph == PH_PREFIX) scan_ph = PH_FAIL;
      else scan_ph = PH_ENDED;
      return;
    end
    case (scan_ph)
      PH_WS, PH_SIGN: begin
        if (scan_ph == PH_WS && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) return;
        if (scan_ph == PH_WS && (c == CH_PLUS || c == CH_MINUS)) begin
          neg_q = (c == CH_MINUS);
          scan_ph = PH_SIGN;
          return;
        end
        if (d > 9) begin
          scan_ph = PH_FAIL;
          return;
        end
        rdx_q = RADIX_DEC;
        if (detect && d == 0) begin
          scan_ph = PH_ZERO;
        end else begin
          scan_ph = PH_DIGITS;
          fold_digit(d);
        end
      end
      PH_ZERO: begin
        if (detect && (c == CH_LX || c == CH_UX)) begin
          scan_ph = PH_PREFIX;
        end else if (detect && d < 8) begin
          rdx_q = RADIX_OCT;
          scan_ph = PH_DIGITS;
          fold_digit(d);
        end else begin
          scan_ph = PH_TRAIL;
          note_suffix(c);
        end
      end
      PH_PREFIX: begin
        if (d >= 16) begin
          scan_ph = PH_FAIL;
        end else begin
          rdx_q = RADIX_HEX;
          scan_ph = PH_DIGITS;
          fold_digit(d);
        end
      end
      PH_DIGITS: begin
        if (d < base_of(rdx_q)) begin
          fold_digit(d);
        end else begin
          scan_ph = PH_TRAIL;
          note_suffix(c);
        end
      end
      default: note_suffix(c);
    endcase
  endtask

  // end of string: range check, sign, then suffix scaling or the no-suffix check by mode
  task finish_string();
    parse_result_t res;
    logic          good;
    logic [63:0]   v;
    logic [63:0]   mult;
    int unsigned   steps;
    good = !(scan_ph == PH_WS || scan_ph == PH_SIGN || scan_ph == PH_PREFIX ||
             scan_ph == PH_FAIL);
    if (ovf_q || (!neg_q && mag_q >= SIGN_LIMIT) || mag_q > SIGN_LIMIT) good = 1'b0;
    v = '0;
    if (good) begin
      v = neg_q ? -mag_q : mag_q;
      if (mode_q == MODE_SUFFIX) begin
        steps = scale_steps(sfx_c[0]);
        mult = 64'd1000;
        case (sfx_n)
          0: steps = 0;
          1: if (steps == 0 && !unit_letter(sfx_c[0])) good = 1'b0;
          2: begin
            if (steps == 0) good = 1'b0;
            else if (binary_letter(sfx_c[1])) mult = 64'd1024;
            else if (!unit_letter(sfx_c[1])) good = 1'b0;
          end
          3: begin
            if (steps == 0 || !binary_letter(sfx_c[1]) || !unit_letter(sfx_c[2])) good = 1'b0;
            else mult = 64'd1024;
          end
          default: good = 1'b0;
        endcase
        if (good) repeat (steps) v = v * mult;
      end else if (mode_q != MODE_PREFIX) begin
        good = (sfx_n == 0);
      end
    end
    if (!good) v = '0;
    res.ok = good;
    res.value = v;
    parse_q.push_back(res);
    clear_scan();
  endtask

  // compare results, track mode, predict on accepted items
  always @(posedge clk) begin
    if (rst) begin
      mode_q = MODE_WHOLE;
      clear_scan();
      parse_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (parse_q.size() == 0) begin
          log_mismatch("result with nothing expected", value, '0);
        end else begin
          head_res = parse_q.pop_front();
          if (ok !== head_res.ok) log_mismatch("ok", 64'(ok), 64'(head_res.ok));
          if (value !== head_res.value) log_mismatch("value", value, head_res.value);
        end
      end
      if (cfg_wr_en) mode_q = cfg_wr_data;
      if (in_valid && !in_stall) begin
        scan_char(ch);
        if (last) finish_string();
      end
    end
    pending <= parse_q.size();
    errors <= mismatch_n;
  end

endmodule

// ===== sim/tb_integer_text_parser_with_size_suffix_core.sv =====
`timescale 1ns / 100ps

module tb_integer_text_parser_with_size_suffix_core;
  import itp_pkg::*;

  localparam int PIPE_DEPTH    = 5;
  localparam int SETTLE_CYCLES = PIPE_DEPTH + 4;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SEGMENT_ITEMS = 115;
  // undefined mode code, decodes like the whole-string mode
  localparam logic [1:0] MODE_ALIAS = 2'd3;
  localparam logic [7:0] CH_TOP     = 8'hFF;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  ch;
  logic        last;
  logic        out_valid;
  logic        out_stall;
  logic        ok;
  logic [63:0] value;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;

  int          mismatches;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_req;
  int          quiet_cycles = 0;
  logic [7:0]  text_q[$];

  integer_text_parser_with_size_suffix_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ch         (ch),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .value      (value),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  itp_scoreboard chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ch         (ch),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .value      (value),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .errors     (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    logic hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_integer_text_parser_with_size_suffix_core NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one character, with an occasional gap before it
  task send_item(input logic [7:0] c, input logic l);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    last <= l;
    do @(posedge clk); while (in_stall);
  endtask

  task send_text();
    for (int i = 0; i < text_q.size(); i++) send_item(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // wait for every parse result and the pipeline to empty
  task drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_mode(input logic [1:0] m);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] rand_digit(input int unsigned base);
    int unsigned v;
    v = $urandom_range(base - 1);
    if (v < 10) return 8'(CH_0 + v);
    return 8'((($urandom_range(1) != 0) ? CH_LA : CH_UA) + v - 10);
  endfunction

  // suffix character by position, sometimes a stray one
  function automatic logic [7:0] size_letter(input int unsigned pos);
    if ($urandom_range(99) < 12) return 8'($urandom_range(33, 126));
    case (pos)
      0: begin
        case ($urandom_range(7))
          0: return CH_LK;
          1: return CH_UK;
          2: return CH_LM;
          3: return CH_UM;
          4: return CH_LG;
          5: return CH_UG;
          6: return CH_LB;
          default: return CH_UB;
        endcase
      end
      1: begin
        case ($urandom_range(3))
          0: return CH_LI;
          1: return CH_UI;
          2: return CH_LB;
          default: return CH_UB;
        endcase
      end
      default: return ($urandom_range(1) != 0) ? CH_LB : CH_UB;
    endcase
  endfunction

  // text after the digits: nothing, a size suffix, junk, or an early zero
  task add_tail();
    int unsigned n;
    case ($urandom_range(9))
      0, 1, 2, 3: ;
      4, 5, 6, 7: begin
        n = ($urandom_range(7) == 0) ? 4 : $urandom_range(1, 3);
        for (int p = 0; p < n; p++) text_q.push_back(size_letter(p));
      end
      8: repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(255)));
      default: begin
        text_q.push_back(CH_NUL);
        repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(255)));
      end
    endcase
    if ($urandom_range(9) == 0) text_q.push_back(CH_NUL);
  endtask

  // mostly well-formed numbers, some range edges, some noise
  task make_random_string();
    int unsigned pick;
    int unsigned n;
    text_q.delete();
    pick = $urandom_range(99);
    if (pick < 8) begin
      case ($urandom_range(6))
        0: add_str("9223372036854775807");
        1: add_str("-9223372036854775808");
        2: add_str("9223372036854775808");
        3: add_str("0x7fffffffffffffff");
        4: add_str("-0X8000000000000000");
        5: add_str("0777777777777777777777");
        default: add_str("-01000000000000000000000");
      endcase
      add_tail();
    end else if (pick < 82) begin
      repeat ($urandom_range(0, 2))
        text_q.push_back(($urandom_range(1) != 0) ? CH_SPACE :
                         8'($urandom_range(CH_TAB, CH_CR)));
      case ($urandom_range(3))
        0: text_q.push_back(CH_PLUS);
        1: text_q.push_back(CH_MINUS);
        default: ;
      endcase
      case ($urandom_range(4))
        0, 1: begin
          n = ($urandom_range(9) == 0) ? $urandom_range(18, 21) : $urandom_range(1, 6);
          text_q.push_back(8'(CH_0 + $urandom_range(1, 9)));
          repeat (n - 1) text_q.push_back(rand_digit(10));
        end
        2: begin
          n = ($urandom_range(9) == 0) ? $urandom_range(20, 23) : $urandom_range(0, 4);
          text_q.push_back(CH_0);
          repeat (n) text_q.push_back(rand_digit(8));
        end
        default: begin
          n = ($urandom_range(9) == 0) ? $urandom_range(15, 17) : $urandom_range(0, 4);
          text_q.push_back(CH_0);
          text_q.push_back(($urandom_range(1) != 0) ? CH_LX : CH_UX);
          repeat (n) text_q.push_back(rand_digit(16));
        end
      endcase
      add_tail();
    end else begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
    end
  endtask

  task run_segment(input logic [1:0] m, input logic with_hold);
    int sent;
    sent = 0;
    write_mode(m);
    if (with_hold) hold_req <= 1'b1;
    while (sent < SEGMENT_ITEMS) begin
      make_random_string();
      sent += text_q.size();
      send_text();
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    ch <= CH_NUL;
    last <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= MODE_WHOLE;
    hold_req <= 1'b0;
    recv_idle_pct <= 0;
    send_idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed strings, whole-string mode
    write_mode(MODE_WHOLE);
    add_str("-12");
    send_text();
    // hex prefix with no digit
    add_str("0x");
    send_text();
    // lone sign
    add_str("+");
    send_text();
    // zero character before last
    add_str("5");
    text_q.push_back(CH_NUL);
    add_str("z");
    send_text();
    add_str("7");
    text_q.push_back(CH_TOP);
    send_text();

    // valid suffix, then suffix too long
    write_mode(MODE_SUFFIX);
    add_str("3Kib");
    send_text();
    add_str("1GiBx");
    send_text();

    write_mode(MODE_PREFIX);
    add_str("09z");
    send_text();

    // undefined mode, octal with a bad digit
    write_mode(MODE_ALIAS);
    add_str("08");
    send_text();

    // random strings under three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 62 : 0;
      recv_idle_pct <= (ph == 0) ? 62 : (ph == 1) ? 6 : 0;
      run_segment(MODE_WHOLE, ph == 2);
      run_segment(MODE_SUFFIX, 1'b0);
      run_segment(MODE_PREFIX, 1'b0);
      run_segment(MODE_SUFFIX, 1'b0);
    end

    drain();
    if (mismatches == 0) begin
      $display("tb_integer_text_parser_with_size_suffix_core OK");
    end else begin
      $display("tb_integer_text_parser_with_size_suffix_core NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/itp_pkg.sv
hw/rtl/itp_scan.sv
hw/rtl/itp_sign.sv
hw/rtl/itp_scale.sv
hw/rtl/integer_text_parser_with_size_suffix_core.sv
hw/rtl/itp_checker.sv
sim/itp_checker.sv
sim/tb_integer_text_parser_with_size_suffix_core.sv
